@@ src/square_tone_generator_macros.svh @@
// assertion macros shared by the tone generator rtl
// relies on clk and rst_n being visible where a macro is used
`ifndef SQUARE_TONE_GENERATOR_MACROS_SVH
`define SQUARE_TONE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define STG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stg assertion failed");
`define STG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stg assertion failed");
`else
`define STG_ASSERT_IMP(label, ante, cons)
`define STG_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ src/stg_pkg.sv @@
// shared types, widths, codes and prescaler tables of the tone generator
// no dependencies
`default_nettype none
package stg_pkg;

  localparam int CLOCK_W    = 27;
  localparam int CPMS_W     = 17;
  localparam int FREQ_W     = 16;
  localparam int LEN_W      = 16;
  localparam int SEL_W      = 3;
  localparam int PCOUNT_W   = 10;
  localparam int CMP_OUT_W  = 8;
  localparam int STATUS_W   = 2;
  localparam int PRESC_NUM  = 5;
  localparam int SHIFT_W    = 4;
  localparam int DIV_CNT_W  = $clog2(CLOCK_W);

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(12000000);
  localparam logic [CPMS_W-1:0]  CPMS_RESET  = CPMS_W'(12000);

  // configuration register indexes
  localparam logic CFG_IDX_CLOCK = 1'b0;
  localparam logic CFG_IDX_CPMS  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_FREQ = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT       = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic                tick;
    logic                reject;
    logic [STATUS_W-1:0] reject_code;
    logic                div_load;
    logic                div_step;
    logic                finish;
  } stg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic playing;
    logic freq_zero;
  } stg_stat_t;

  // prescaler division ratio, codes past 4 behave as 1024
  function automatic logic [PCOUNT_W:0] presc_div(input logic [SEL_W-1:0] sel);
    logic [PCOUNT_W:0] d;
    unique case (sel)
      3'd0:    d = 11'd1;
      3'd1:    d = 11'd8;
      3'd2:    d = 11'd64;
      3'd3:    d = 11'd256;
      default: d = 11'd1024;
    endcase
    return d;
  endfunction

  // log2 of 2 * prescaler: shift applied to clock_hz / tone_hz
  function automatic logic [SHIFT_W-1:0] presc_shift(input logic [SEL_W-1:0] sel);
    logic [SHIFT_W-1:0] s;
    unique case (sel)
      3'd0:    s = 4'd1;
      3'd1:    s = 4'd4;
      3'd2:    s = 4'd7;
      3'd3:    s = 4'd9;
      default: s = 4'd11;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ src/square_tone_generator.sv @@
// square_tone_generator: ctc timer based square-wave tone source, one result per request
// tick request: accepted every cycle while idle and results are taken, result registered in the next cycle
// start request: clock_hz / tone_hz by a 27-step serial divider, unless rejected,
//   and no new request is taken until its result is registered
// synchronous active-low reset clears tone state and restores clock_hz and cycles_per_ms
`default_nettype none
module square_tone_generator #(
  parameter int TIMER_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [stg_pkg::CLOCK_W-1:0]       cfg_data,
  // requests
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_req_type,
  input  wire logic [stg_pkg::FREQ_W-1:0]        in_tone_hz,
  input  wire logic [stg_pkg::LEN_W-1:0]         in_length_ms,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_speaker_level,
  output logic                                   out_speaker_drive,
  output logic                                   out_busy_res,
  output logic                                   out_tone_done,
  output logic [stg_pkg::SEL_W-1:0]              out_prescale_code,
  output logic [stg_pkg::CMP_OUT_W-1:0]          out_compare_value,
  output logic [stg_pkg::STATUS_W-1:0]           out_status
);

  // commands from the sequencer and status back from the datapath
  stg_pkg::stg_cmd_t  cmd;
  stg_pkg::stg_stat_t stat;

  // sequencer: owns the request handshake, the result valid and the divider step count
  stg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // datapath: config, divider, prescaler pick, ctc counter, duration counter,
  // and the result register that holds the payload until taken
  stg_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_tone_hz        (in_tone_hz),
    .in_length_ms      (in_length_ms),
    .cmd               (cmd),
    .stat              (stat),
    .out_speaker_level (out_speaker_level),
    .out_speaker_drive (out_speaker_drive),
    .out_busy_res      (out_busy_res),
    .out_tone_done     (out_tone_done),
    .out_prescale_code (out_prescale_code),
    .out_compare_value (out_compare_value),
    .out_status        (out_status)
  );

endmodule
`default_nettype wire

@@ src/stg_ctrl.sv @@
// request sequencing for the tone generator: handshakes, divider steps, result slot
// depends on stg_pkg and square_tone_generator_macros.svh
`default_nettype none
`include "square_tone_generator_macros.svh"
module stg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stg_pkg::stg_cmd_t       cmd,
  input  wire stg_pkg::stg_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t                          state_r, state_nxt;
  logic [stg_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_req_type) begin
            cmd.tick      = 1'b1;
            out_valid_nxt = 1'b1;
          end else if (stat.playing) begin
            cmd.reject      = 1'b1;
            cmd.reject_code = stg_pkg::ST_BUSY;
            out_valid_nxt   = 1'b1;
          end else if (stat.freq_zero) begin
            cmd.reject      = 1'b1;
            cmd.reject_code = stg_pkg::ST_ZERO_FREQ;
            out_valid_nxt   = 1'b1;
          end else begin
            cmd.div_load = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == stg_pkg::DIV_CNT_W'(stg_pkg::CLOCK_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result slot is free whenever a start finishes
  `STG_ASSERT_IMP(a_fin_slot_free, state_r == S_FIN, !out_valid_r)
  // no result pending while the divider runs
  `STG_ASSERT_IMP(a_div_no_result, state_r == S_DIV, !out_valid_r && !in_ready)
  // a start that is taken runs the divider next
  `STG_ASSERT_NXT(a_start_divides,
    accept && in_req_type && !stat.playing && !stat.freq_zero, state_r == S_DIV)
  // a taken tick yields a result in the next cycle
  `STG_ASSERT_NXT(a_tick_result, accept && !in_req_type, out_valid_r)

endmodule
`default_nettype wire

@@ src/stg_dp.sv @@
// tone generator datapath: config registers, serial divider, timer state, result register
// depends on stg_pkg
`default_nettype none
module stg_dp #(
  parameter int TIMER_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [stg_pkg::CLOCK_W-1:0]       cfg_data,
  input  wire logic [stg_pkg::FREQ_W-1:0]        in_tone_hz,
  input  wire logic [stg_pkg::LEN_W-1:0]         in_length_ms,
  input  wire stg_pkg::stg_cmd_t                 cmd,
  output stg_pkg::stg_stat_t                     stat,
  output logic                                   out_speaker_level,
  output logic                                   out_speaker_drive,
  output logic                                   out_busy_res,
  output logic                                   out_tone_done,
  output logic [stg_pkg::SEL_W-1:0]              out_prescale_code,
  output logic [stg_pkg::CMP_OUT_W-1:0]          out_compare_value,
  output logic [stg_pkg::STATUS_W-1:0]           out_status
);

  localparam int CW = stg_pkg::CLOCK_W;
  localparam logic [CW:0] TIMER_LIM = (CW + 1)'(1) << TIMER_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // configuration
  logic [CW-1:0]              clock_r;
  logic [stg_pkg::CPMS_W-1:0] cpms_r;

  // tone state
  logic                         pin_latch_r, pin_latch_nxt;
  logic                         drive_on_r, drive_on_nxt;
  logic                         playing_r, playing_nxt;
  logic [TIMER_BITS-1:0]        match_r, match_nxt;
  logic [stg_pkg::SEL_W-1:0]    sel_r, sel_nxt;
  logic [stg_pkg::PCOUNT_W-1:0] pcount_r, pcount_nxt;
  logic [TIMER_BITS-1:0]        timer_r, timer_nxt;
  logic [stg_pkg::LEN_W-1:0]    ms_rem_r, ms_rem_nxt;
  logic [stg_pkg::CPMS_W-1:0]   tick_ms_r, tick_ms_nxt;
  logic                         done_nxt;
  logic [stg_pkg::STATUS_W-1:0] status_nxt;

  // divider
  logic [CW-1:0]               quo_r;
  logic [stg_pkg::FREQ_W-1:0]  rem_r;
  logic [stg_pkg::FREQ_W-1:0]  divisor_r;
  logic [stg_pkg::LEN_W-1:0]   len_r;
  logic [stg_pkg::FREQ_W:0]    trial;
  logic                        trial_ge;

  // tick arithmetic
  logic [stg_pkg::PCOUNT_W:0]  pdiv;
  logic [stg_pkg::PCOUNT_W:0]  pc_inc;
  logic [stg_pkg::CPMS_W-1:0]  cpm;
  logic [stg_pkg::CPMS_W:0]    tk_inc;
  logic [stg_pkg::LEN_W-1:0]   ms_dec;

  // prescaler choice
  logic [TIMER_BITS-1:0]       cv_sel;
  logic [stg_pkg::SEL_W-1:0]   pick_sel;
  logic                        pick_fit;

  assign cfg_ready      = 1'b1;
  assign stat.playing   = playing_r;
  assign stat.freq_zero = (in_tone_hz == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= stg_pkg::CLOCK_RESET;
      cpms_r  <= stg_pkg::CPMS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stg_pkg::CFG_IDX_CLOCK: clock_r <= cfg_data;
        stg_pkg::CFG_IDX_CPMS:  cpms_r  <= cfg_data[stg_pkg::CPMS_W-1:0];
        default:                clock_r <= clock_r;
      endcase
    end
  end

  // restoring divider, one quotient bit per step
  assign trial    = {rem_r, quo_r[CW-1]};
  assign trial_ge = (trial >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r     <= clock_r;
      rem_r     <= '0;
      divisor_r <= in_tone_hz;
      len_r     <= in_length_ms;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[CW-2:0], trial_ge};
      rem_r <= trial_ge ? stg_pkg::FREQ_W'(trial - {1'b0, divisor_r})
                        : trial[stg_pkg::FREQ_W-1:0];
    end
  end

  // first prescaler whose compare value fits
  always_comb begin
    logic [CW-1:0] q;
    logic [CW-1:0] qm1;
    cv_sel   = TIMER_MAX;
    pick_sel = stg_pkg::SEL_W'(stg_pkg::PRESC_NUM - 1);
    pick_fit = 1'b0;
    for (int i = 0; i < stg_pkg::PRESC_NUM; i++) begin
      q   = quo_r >> stg_pkg::presc_shift(stg_pkg::SEL_W'(i));
      qm1 = q - 1'b1;
      if (!pick_fit && ({1'b0, q} <= TIMER_LIM)) begin
        pick_fit = 1'b1;
        pick_sel = stg_pkg::SEL_W'(i);
        cv_sel   = (q == '0) ? '0 : qm1[TIMER_BITS-1:0];
      end
    end
  end

  assign pdiv   = stg_pkg::presc_div(sel_r);
  assign pc_inc = {1'b0, pcount_r} + 1'b1;
  assign cpm    = (cpms_r == '0) ? stg_pkg::CPMS_W'(1) : cpms_r;
  assign tk_inc = {1'b0, tick_ms_r} + 1'b1;
  assign ms_dec = ms_rem_r - 1'b1;

  always_comb begin
    pin_latch_nxt = pin_latch_r;
    drive_on_nxt  = drive_on_r;
    playing_nxt   = playing_r;
    match_nxt     = match_r;
    sel_nxt       = sel_r;
    pcount_nxt    = pcount_r;
    timer_nxt     = timer_r;
    ms_rem_nxt    = ms_rem_r;
    tick_ms_nxt   = tick_ms_r;
    done_nxt      = 1'b0;
    status_nxt    = stg_pkg::ST_OK;
    if (cmd.reject) begin
      status_nxt = cmd.reject_code;
    end else if (cmd.finish) begin
      match_nxt   = cv_sel;
      sel_nxt     = pick_sel;
      pcount_nxt  = '0;
      timer_nxt   = '0;
      tick_ms_nxt = '0;
      ms_rem_nxt  = len_r;
      playing_nxt = (len_r != '0);
      drive_on_nxt = (len_r != '0);
      done_nxt    = (len_r == '0);
      status_nxt  = pick_fit ? stg_pkg::ST_OK : stg_pkg::ST_SAT;
    end else if (cmd.tick && playing_r) begin
      if (pc_inc >= pdiv) begin
        pcount_nxt = '0;
        if (timer_r == match_r) begin
          timer_nxt     = '0;
          pin_latch_nxt = !pin_latch_r;
        end else begin
          timer_nxt = timer_r + 1'b1;
        end
      end else begin
        pcount_nxt = pc_inc[stg_pkg::PCOUNT_W-1:0];
      end
      if (tk_inc >= {1'b0, cpm}) begin
        tick_ms_nxt = '0;
        ms_rem_nxt  = ms_dec;
        if (ms_dec == '0) begin
          playing_nxt  = 1'b0;
          drive_on_nxt = 1'b0;
          done_nxt     = 1'b1;
        end
      end else begin
        tick_ms_nxt = tk_inc[stg_pkg::CPMS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_latch_r <= 1'b0;
      drive_on_r  <= 1'b0;
      playing_r   <= 1'b0;
      match_r     <= '0;
      sel_r       <= '0;
      pcount_r    <= '0;
      timer_r     <= '0;
      ms_rem_r    <= '0;
      tick_ms_r   <= '0;
    end else begin
      pin_latch_r <= pin_latch_nxt;
      drive_on_r  <= drive_on_nxt;
      playing_r   <= playing_nxt;
      match_r     <= match_nxt;
      sel_r       <= sel_nxt;
      pcount_r    <= pcount_nxt;
      timer_r     <= timer_nxt;
      ms_rem_r    <= ms_rem_nxt;
      tick_ms_r   <= tick_ms_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.tick || cmd.reject || cmd.finish) begin
      out_speaker_level <= pin_latch_nxt;
      out_speaker_drive <= drive_on_nxt;
      out_busy_res      <= playing_nxt;
      out_tone_done     <= done_nxt;
      out_prescale_code <= sel_nxt;
      out_compare_value <= match_nxt[stg_pkg::CMP_OUT_W-1:0];
      out_status        <= status_nxt;
    end
  end

endmodule
`default_nettype wire
